// ===== hw/rtl/rpqpc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package rpqpc_pkg;

  // Width of the free-running time base; timestamps are truncated or zero-extended to it.
  localparam int TimeWidth  = 32;
  localparam int StampWidth = 32;
  localparam int PosWidth   = 32;
  localparam int RatioWidth = 7;
  localparam int ThreshWidth = 32;
  localparam int CfgIdxWidth = 2;
  localparam int CfgDataWidth = 32;

  // Products are kept at full width so the ratio test never overflows.
  localparam int MulWidth = TimeWidth + RatioWidth;
  localparam int CmpWidth = (TimeWidth > ThreshWidth) ? TimeWidth : ThreshWidth;

  localparam logic [RatioWidth-1:0] PercentScale = RatioWidth'(100);

  localparam logic                   ResetCountDown  = 1'b0;
  localparam logic                   ResetDebounceEn = 1'b1;
  localparam logic [ThreshWidth-1:0] ResetThreshold  = ThreshWidth'(20000);
  localparam logic [RatioWidth-1:0]  ResetRatio      = RatioWidth'(60);

  typedef enum logic {
    OP_EDGE  = 1'b0,
    OP_CLEAR = 1'b1
  } opcode_e;

  typedef enum logic [CfgIdxWidth-1:0] {
    REG_COUNT_DOWN  = 2'd0,
    REG_DEBOUNCE_EN = 2'd1,
    REG_THRESHOLD   = 2'd2,
    REG_RATIO       = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic                   count_down;
    logic                   debounce_enable;
    logic [ThreshWidth-1:0] inactivity_threshold_us;
    logic [RatioWidth-1:0]  min_ratio_percent;
  } cfg_t;

endpackage
`default_nettype wire

// ===== hw/rtl/rpqpc_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface rpqpc_in_if;
  logic                                valid;
  logic                                ready;
  logic                                opcode;
  logic [rpqpc_pkg::StampWidth-1:0]    timestamp_us;

  modport source (output valid, output opcode, output timestamp_us, input ready);
  modport sink   (input valid, input opcode, input timestamp_us, output ready);
endinterface

interface rpqpc_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [rpqpc_pkg::PosWidth-1:0] position;
  logic                                counted;

  modport source (output valid, output position, output counted, input ready);
  modport sink   (input valid, input position, input counted, output ready);
endinterface

interface rpqpc_cfg_if;
  logic                                  valid;
  logic                                  ready;
  logic [rpqpc_pkg::CfgIdxWidth-1:0]     index;
  logic [rpqpc_pkg::CfgDataWidth-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/rpqpc_qualify.sv =====
`timescale 1ns / 1ps
`default_nettype none
module rpqpc_qualify (
  input  rpqpc_pkg::cfg_t                      cfg_i,
  input  logic [rpqpc_pkg::TimeWidth-1:0]      interval_i,
  input  logic [rpqpc_pkg::TimeWidth-1:0]      prev_interval_i,
  output logic                                 pass_o
);
  import rpqpc_pkg::*;

  logic [MulWidth-1:0] scaled_now;
  logic [MulWidth-1:0] scaled_prev;
  logic                idle_gap;

  // Both products at full width.
  assign scaled_now  = MulWidth'(interval_i) * MulWidth'(PercentScale);
  assign scaled_prev = MulWidth'(prev_interval_i) * MulWidth'(cfg_i.min_ratio_percent);

  assign idle_gap = CmpWidth'(prev_interval_i) > CmpWidth'(cfg_i.inactivity_threshold_us);

  assign pass_o = !cfg_i.debounce_enable || idle_gap || (scaled_now > scaled_prev);

endmodule
`default_nettype wire

// ===== hw/rtl/ripple_pulse_qualified_position_counter_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Ripple-pulse position counter: each input transfer is either a ripple edge with its
// microsecond timestamp or a clear command, and yields exactly one result carrying the
// position after that item and whether the edge was counted. An edge is counted when
// debouncing is off, when the previous interval exceeded the inactivity threshold, or when
// interval*100 exceeds previous_interval*min_ratio_percent; a counted edge steps the
// signed 32-bit position down when count_down is set and up otherwise, wrapping. A clear
// zeroes the position and leaves the timing history alone. The block takes one item per
// cycle while the result side is not stalled; each item passes through the input register
// and then the result register, around a single pass of subtract, two narrow multiplies and
// the compares. The result register holds while the downstream side stalls, and the input
// register keeps taking items until both are full. Configuration writes are always ready
// and take effect at once; write them only while the block is idle.
module ripple_pulse_qualified_position_counter_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  rpqpc_in_if.sink          in_i,
  rpqpc_out_if.source       out_o,
  rpqpc_cfg_if.sink         cfg_i
);
  import rpqpc_pkg::*;

  // Configuration registers
  cfg_t cfg_q;

  // Input stage
  logic                  in_valid_q;
  logic                  in_opcode_q;
  logic [TimeWidth-1:0]  in_time_q;

  // Timing history and position
  logic [TimeWidth-1:0]  prev_time_q, prev_time_d;
  logic [TimeWidth-1:0]  prev_interval_q, prev_interval_d;
  logic [PosWidth-1:0]   pos_q, pos_d;

  // Result stage
  logic                  out_valid_q;
  logic [PosWidth-1:0]   out_pos_q;
  logic                  out_counted_q;
  logic                  counted_d;

  logic                  advance;
  logic                  in_ready;
  logic [TimeWidth-1:0]  interval;
  logic                  pass;

  // Move the held item into the result register when that register is free or draining.
  assign advance  = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_ready = !in_valid_q || advance;

  assign in_i.ready  = in_ready;
  assign cfg_i.ready = 1'b1;

  assign out_o.valid    = out_valid_q;
  assign out_o.position = out_pos_q;
  assign out_o.counted  = out_counted_q;

  // Modular interval since the previous edge.
  assign interval = in_time_q - prev_time_q;

  rpqpc_qualify u_qualify (
    .cfg_i           (cfg_q),
    .interval_i      (interval),
    .prev_interval_i (prev_interval_q),
    .pass_o          (pass)
  );

  always_comb begin
    prev_time_d     = prev_time_q;
    prev_interval_d = prev_interval_q;
    pos_d           = pos_q;
    counted_d       = 1'b0;
    if (in_opcode_q == OP_CLEAR) begin
      // Drop the position; timing history stays.
      pos_d = '0;
    end else begin
      prev_time_d     = in_time_q;
      prev_interval_d = interval;
      if (pass) begin
        counted_d = 1'b1;
        pos_d     = cfg_q.count_down ? pos_q - PosWidth'(1) : pos_q + PosWidth'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.count_down              <= ResetCountDown;
      cfg_q.debounce_enable         <= ResetDebounceEn;
      cfg_q.inactivity_threshold_us <= ResetThreshold;
      cfg_q.min_ratio_percent       <= ResetRatio;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_COUNT_DOWN:  cfg_q.count_down              <= cfg_i.data[0];
        REG_DEBOUNCE_EN: cfg_q.debounce_enable         <= cfg_i.data[0];
        REG_THRESHOLD:   cfg_q.inactivity_threshold_us <= ThreshWidth'(cfg_i.data);
        REG_RATIO:       cfg_q.min_ratio_percent       <= cfg_i.data[RatioWidth-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q      <= 1'b0;
      out_valid_q     <= 1'b0;
      prev_time_q     <= '0;
      prev_interval_q <= '0;
      pos_q           <= '0;
    end else begin
      if (in_ready) begin
        in_valid_q <= in_i.valid;
      end
      if (advance) begin
        out_valid_q     <= 1'b1;
        prev_time_q     <= prev_time_d;
        prev_interval_q <= prev_interval_d;
        pos_q           <= pos_d;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers: no reset needed.
  always_ff @(posedge clk_i) begin
    if (in_ready && in_i.valid) begin
      in_opcode_q <= in_i.opcode;
      in_time_q   <= TimeWidth'(in_i.timestamp_us);
    end
    if (advance) begin
      out_pos_q     <= pos_d;
      out_counted_q <= counted_d;
    end
  end

  // A clear always reports position zero and no count.
  a_clear_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && (in_opcode_q == OP_CLEAR) |=> out_valid_q && (out_pos_q == '0) && !out_counted_q)
    else $error("clear did not report zero position");

  // With debouncing off every edge is counted.
  a_no_debounce: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && (in_opcode_q == OP_EDGE) && !cfg_q.debounce_enable |=> out_counted_q)
    else $error("edge dropped with debouncing off");

  // An edge that is not counted leaves the position as it was.
  a_hold_position: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && (in_opcode_q == OP_EDGE) && !pass |=> (out_pos_q == $past(pos_q)))
    else $error("uncounted edge moved position");

  // The reported position always matches the live position state.
  a_result_tracks_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> (out_pos_q == pos_q))
    else $error("result position differs from position state");

  // The input register is never overwritten while its item waits.
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !advance |-> !in_ready)
    else $error("input stage overrun");

endmodule
`default_nettype wire

// ===== dv/ripple_pulse_qualified_position_counter_core_tb.sv =====
`timescale 1ns / 1ps
module ripple_pulse_qualified_position_counter_core_tb;
  import rpqpc_pkg::*;

  localparam int HalfPeriod  = 5;
  // Slowest correct run is roughly 850 items, each with its worst gap, stall and pipeline delay.
  // Allow many times that.
  localparam int CycleLimit  = 400000;
  localparam int DrainCycles = 8;
  localparam int SettleCycles = 4;
  localparam int PhaseCount  = 8;
  localparam int PhaseItems  = 100;

  typedef struct packed {
    logic signed [PosWidth-1:0] position;
    logic                       counted;
  } position_result_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  rpqpc_in_if  edge_bus ();
  rpqpc_out_if pos_bus ();
  rpqpc_cfg_if cfg_bus ();

  ripple_pulse_qualified_position_counter_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (edge_bus),
    .out_o  (pos_bus),
    .cfg_i  (cfg_bus)
  );

  // Shadow copy of the block: registers, timing history and position.
  cfg_t                  model_cfg;
  logic [TimeWidth-1:0]  last_edge_time;
  logic [TimeWidth-1:0]  last_interval;
  logic [PosWidth-1:0]   model_position;

  // Positions still owed by the block, oldest first.
  position_result_t expected_positions[$];

  int mismatch_count;
  int stall_left;
  // When set, the side runs with no idle cycles at all.
  bit src_steady;
  bit sink_steady;

  always #HalfPeriod clk_i = ~clk_i;

  // Abort a hung run.
  initial begin
    repeat (CycleLimit) @(posedge clk_i);
    $display("end of test: mismatches");
    $finish;
  end

  function automatic int idle_cycles(bit steady);
    if (steady) return 0;
    return $urandom_range(0, 10);
  endfunction

  // Compute the result of one accepted item and advance the shadow state.
  function automatic position_result_t next_position(opcode_e op,
                                                     logic [StampWidth-1:0] stamp);
    logic [TimeWidth-1:0] now;
    logic [TimeWidth-1:0] interval;
    logic [MulWidth-1:0]  scaled_now;
    logic [MulWidth-1:0]  scaled_prev;
    logic                 admit;
    position_result_t     res;
    res.counted = 1'b0;
    if (op == OP_CLEAR) begin
      // Zero the position only; keep the timing history.
      model_position = '0;
    end else begin
      now         = TimeWidth'(stamp);
      interval    = now - last_edge_time;
      // Compare both products at full width so neither can overflow.
      scaled_now  = MulWidth'(interval) * MulWidth'(PercentScale);
      scaled_prev = MulWidth'(last_interval) * MulWidth'(model_cfg.min_ratio_percent);
      admit = !model_cfg.debounce_enable
           || (CmpWidth'(last_interval) > CmpWidth'(model_cfg.inactivity_threshold_us))
           || (scaled_now > scaled_prev);
      if (admit) begin
        model_position = model_cfg.count_down ? model_position - PosWidth'(1)
                                              : model_position + PosWidth'(1);
        res.counted = 1'b1;
      end
      last_edge_time = now;
      last_interval  = interval;
    end
    res.position = model_position;
    return res;
  endfunction

  // Offer one item after a random gap, hold it until the transfer, then log its result.
  task automatic send_item(opcode_e op, logic [StampWidth-1:0] stamp);
    int gap;
    gap = idle_cycles(src_steady);
    @(negedge clk_i);
    if (gap > 0) begin
      edge_bus.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    edge_bus.opcode       = op;
    edge_bus.timestamp_us = stamp;
    edge_bus.valid        = 1'b1;
    do @(posedge clk_i); while (!edge_bus.ready);
    expected_positions.push_back(next_position(op, stamp));
  endtask

  // Drop valid and hold until every owed result has come back.
  task automatic wait_idle();
    @(negedge clk_i);
    edge_bus.valid = 1'b0;
    while (expected_positions.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic cfg_write(cfg_reg_e idx, logic [CfgDataWidth-1:0] data);
    @(negedge clk_i);
    cfg_bus.index = idx;
    cfg_bus.data  = data;
    cfg_bus.valid = 1'b1;
    do @(posedge clk_i); while (!cfg_bus.ready);
    case (idx)
      REG_COUNT_DOWN:  model_cfg.count_down              = data[0];
      REG_DEBOUNCE_EN: model_cfg.debounce_enable         = data[0];
      REG_THRESHOLD:   model_cfg.inactivity_threshold_us = data[ThreshWidth-1:0];
      REG_RATIO:       model_cfg.min_ratio_percent       = data[RatioWidth-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_bus.valid = 1'b0;
  endtask

  // Write all four registers; fill unused upper bits with noise so the masking is exercised.
  task automatic program_registers(logic down, logic debounce,
                                   logic [ThreshWidth-1:0] threshold,
                                   logic [RatioWidth-1:0] ratio);
    cfg_write(REG_COUNT_DOWN,  (32'($urandom()) & ~32'h1) | 32'(down));
    cfg_write(REG_DEBOUNCE_EN, (32'($urandom()) & ~32'h1) | 32'(debounce));
    cfg_write(REG_THRESHOLD,   CfgDataWidth'(threshold));
    cfg_write(REG_RATIO,       (32'($urandom()) & ~32'h7F) | 32'(ratio));
  endtask

  // Release ready only after the stall drawn for the previous transfer runs out.
  initial begin
    pos_bus.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        pos_bus.ready = 1'b0;
        stall_left--;
      end else begin
        pos_bus.ready = 1'b1;
      end
    end
  end

  // Compare each result transfer against the oldest owed result.
  always @(posedge clk_i) begin : check_results
    position_result_t want;
    if (rst_ni && pos_bus.valid && pos_bus.ready) begin
      if (expected_positions.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected result: expected none, actual position %0d counted %0b",
                 $time, pos_bus.position, pos_bus.counted);
      end else begin
        want = expected_positions.pop_front();
        if (pos_bus.position !== want.position) begin
          mismatch_count++;
          $display("%0t: position mismatch: expected %0d, actual %0d",
                   $time, want.position, pos_bus.position);
        end
        if (pos_bus.counted !== want.counted) begin
          mismatch_count++;
          $display("%0t: counted mismatch: expected %0b, actual %0b",
                   $time, want.counted, pos_bus.counted);
        end
      end
      stall_left = idle_cycles(sink_steady);
    end
  end

  // First edge measures from time zero: a zero interval against a zero history is rejected.
  task automatic test_first_edges();
    send_item(OP_EDGE, 32'd0);
    send_item(OP_EDGE, 32'd1000);
    send_item(OP_EDGE, 32'd1500);   // shorter than 60 percent of the last interval
    send_item(OP_EDGE, 32'd3000);
  endtask

  // Intervals across the top of the time base wrap modulo 2^TimeWidth.
  task automatic test_timestamp_wrap();
    send_item(OP_EDGE, 32'hFFFF_FF00);
    send_item(OP_EDGE, 32'h0000_0050);
    send_item(OP_EDGE, 32'hFFFF_FFFF);
    send_item(OP_EDGE, 32'h0000_0000);
  endtask

  // Clear zeroes the position and reports not counted, whatever its stamp.
  task automatic test_clear_command();
    send_item(OP_CLEAR, 32'hFFFF_FFFF);
    send_item(OP_EDGE,  32'h0000_4000);
    send_item(OP_CLEAR, 32'h0000_0000);
    send_item(OP_CLEAR, 32'h5A5A_A5A5);
  endtask

  task automatic test_register_extremes();
    // Count every edge, downward, so the position goes negative.
    wait_idle();
    program_registers(1'b1, 1'b0, ResetThreshold, ResetRatio);
    send_item(OP_EDGE, 32'd100);
    send_item(OP_EDGE, 32'd200);
    send_item(OP_EDGE, 32'd300);
    // Zero threshold: any nonzero history admits the next edge, even a zero interval.
    wait_idle();
    program_registers(1'b0, 1'b1, '0, 7'd127);
    send_item(OP_EDGE, 32'd400);
    send_item(OP_EDGE, 32'd400);
    send_item(OP_EDGE, 32'd500);
    // Highest threshold and ratio: only a clearly longer interval counts.
    wait_idle();
    program_registers(1'b0, 1'b1, '1, 7'd127);
    send_item(OP_EDGE, 32'd600);
    send_item(OP_EDGE, 32'd800);
    // Zero ratio: anything but a zero interval counts.
    wait_idle();
    program_registers(1'b0, 1'b1, '1, 7'd0);
    send_item(OP_EDGE, 32'd800);
    send_item(OP_EDGE, 32'd801);
  endtask

  // Mostly plausible ripple trains with jitter, plus glitches, pauses, clears and noise.
  task automatic test_random_phases();
    logic [TimeWidth-1:0] stamp;
    int unsigned          period;
    int                   pick;
    for (int phase = 0; phase < PhaseCount; phase++) begin
      period = $urandom_range(20, 4000);
      wait_idle();
      case (phase)
        0: program_registers(1'b0, 1'b1, ResetThreshold, ResetRatio);
        1: program_registers(1'b1, 1'b1, '0, RatioWidth'($urandom_range(0, 127)));
        2: program_registers(1'b0, 1'b1, '1, 7'd127);
        3: program_registers(1'b0, 1'b1, ThreshWidth'(2 * period), 7'd0);
        4: program_registers(1'b1, 1'b0, ThreshWidth'($urandom()),
                             RatioWidth'($urandom()));
        default: program_registers(1'($urandom()), ($urandom_range(0, 3) != 0),
                                   ThreshWidth'($urandom_range(0, 3 * period)),
                                   RatioWidth'($urandom_range(40, 100)));
      endcase
      src_steady  = ($urandom_range(0, 3) == 0);
      sink_steady = ($urandom_range(0, 3) == 0);
      // Start one phase just below the top of the time base to force a wrap.
      stamp = (phase == 2) ? 32'hFFFF_F000 : 32'($urandom());
      for (int n = 0; n < PhaseItems; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
          stamp += period + $urandom_range(0, period / 4) - period / 8;
          send_item(OP_EDGE, stamp);
        end else if (pick < 80) begin
          stamp += $urandom_range(0, period / 2);
          send_item(OP_EDGE, stamp);
        end else if (pick < 85) begin
          stamp += model_cfg.inactivity_threshold_us + $urandom_range(1, 5000);
          send_item(OP_EDGE, stamp);
        end else if (pick < 90) begin
          send_item(OP_CLEAR, 32'($urandom()));
        end else begin
          send_item(opcode_e'($urandom_range(0, 1)), 32'($urandom()));
        end
      end
    end
  endtask

  initial begin
    edge_bus.valid        = 1'b0;
    edge_bus.opcode       = OP_EDGE;
    edge_bus.timestamp_us = '0;
    cfg_bus.valid         = 1'b0;
    cfg_bus.index         = REG_COUNT_DOWN;
    cfg_bus.data          = '0;
    mismatch_count        = 0;
    stall_left            = 0;
    src_steady            = 1'b0;
    sink_steady           = 1'b0;
    model_cfg.count_down              = ResetCountDown;
    model_cfg.debounce_enable         = ResetDebounceEn;
    model_cfg.inactivity_threshold_us = ResetThreshold;
    model_cfg.min_ratio_percent       = ResetRatio;
    last_edge_time = '0;
    last_interval  = '0;
    model_position = '0;

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_first_edges();
    test_timestamp_wrap();
    test_clear_command();
    test_register_extremes();
    test_random_phases();

    // Drain the pipe, then keep watching for stray results.
    @(negedge clk_i);
    edge_bus.valid = 1'b0;
    while (expected_positions.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
